@@ rtl/svcb_pkg.sv @@
// Shared types and constants for the SVCB record-data validator.
// Request structs for the byte input and the per-record result.
// No dependencies.
package svcb_pkg;

  // Name must end within this many bytes after the priority
  localparam int MaxNameBytes = 256;
  // Name-length byte positions at or beyond this value are out of limit
  localparam logic [15:0] NameLimitPos = 16'(MaxNameBytes + 2);

  // Parameter keys of interest
  localparam logic [15:0] KeyMandatory = 16'd0;
  localparam logic [15:0] KeyPort      = 16'd3;
  localparam logic [15:0] KeyDoh       = 16'd32768;

  // One input request: a record byte and its final-byte mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } svcb_in_t;

  // One result request, produced on the final byte of a record
  typedef struct packed {
    logic [15:0] priority_res;
    logic        is_alias;
    logic        name_ok;
    logic        record_valid;
    logic [15:0] port;
  } svcb_out_t;

endpackage

@@ rtl/svcb_parser.sv @@
// Byte-wise SVCB record-data parser: phase tracking, name skip and entry walk.
// Produces the result combinationally on the final byte and clears itself.
// Depends on svcb_pkg.
module svcb_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  svcb_pkg::svcb_in_t   byte_i,
  output logic                 res_valid_o,
  output svcb_pkg::svcb_out_t  res_o
);

  localparam logic [3:0] PhPriHi    = 4'd0;
  localparam logic [3:0] PhPriLo    = 4'd1;
  localparam logic [3:0] PhNameLen  = 4'd2;
  localparam logic [3:0] PhNameSkip = 4'd3;
  localparam logic [3:0] PhNameBad  = 4'd4;
  localparam logic [3:0] PhKeyHi    = 4'd5;
  localparam logic [3:0] PhKeyLo    = 4'd6;
  localparam logic [3:0] PhLenHi    = 4'd7;
  localparam logic [3:0] PhLenLo    = 4'd8;
  localparam logic [3:0] PhValue    = 4'd9;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] pos;
    logic [7:0]  skip_left;
    logic [15:0] pri;
    logic [15:0] key;
    logic [15:0] value_left;
    logic [7:0]  pair_hi;
    logic        pair_half;
    logic        pend_invalid;
    logic [15:0] pend_port;
    logic [15:0] value_len;
    logic        mand_seen;
    logic        mand_invalid;
    logic        port_seen;
    logic [15:0] port_val;
    logic        name_good;
  } parse_state_t;

  parse_state_t st_q, st_d, nx;
  logic         big_enough, alias_form;

  // True when a listed mandatory key names a known parameter
  function automatic logic listed_key_ok(input logic [15:0] k);
    logic ok;
    ok = ((k >= 16'd1) && (k <= 16'd6)) || (k == svcb_pkg::KeyDoh);
    return ok;
  endfunction

  // One byte step of the parse
  always_comb begin
    logic [7:0]  b;
    logic [15:0] pair;
    logic        finish;
    b      = byte_i.data_byte;
    pair   = {st_q.pair_hi, b};
    finish = 1'b0;
    nx     = st_q;
    unique case (st_q.phase)
      PhPriHi: begin
        nx.pri   = {b, 8'd0};
        nx.phase = PhPriLo;
      end
      PhPriLo: begin
        nx.pri   = {st_q.pri[15:8], b};
        nx.phase = PhNameLen;
      end
      PhNameLen: begin
        if (st_q.pos >= svcb_pkg::NameLimitPos) begin
          nx.phase = PhNameBad;
        end else if (b == 8'd0) begin
          nx.name_good = 1'b1;
          nx.phase     = PhKeyHi;
        end else begin
          nx.skip_left = b;
          nx.phase     = PhNameSkip;
        end
      end
      PhNameSkip: begin
        nx.skip_left = st_q.skip_left - 8'd1;
        if (st_q.skip_left == 8'd1) nx.phase = PhNameLen;
      end
      PhKeyHi: begin
        nx.pair_hi = b;
        nx.phase   = PhKeyLo;
      end
      PhKeyLo: begin
        nx.key   = pair;
        nx.phase = PhLenHi;
      end
      PhLenHi: begin
        nx.pair_hi = b;
        nx.phase   = PhLenLo;
      end
      PhLenLo: begin
        nx.value_len    = pair;
        nx.value_left   = pair;
        nx.pend_invalid = 1'b0;
        nx.pend_port    = 16'd0;
        nx.pair_half    = 1'b0;
        if (pair == 16'd0) finish = 1'b1;
        else nx.phase = PhValue;
      end
      PhValue: begin
        // collect listed keys of the first mandatory entry
        if (st_q.key == svcb_pkg::KeyMandatory && !st_q.mand_seen) begin
          if (!st_q.pair_half) begin
            nx.pair_hi   = b;
            nx.pair_half = 1'b1;
          end else begin
            if (!listed_key_ok(pair)) nx.pend_invalid = 1'b1;
            nx.pair_half = 1'b0;
          end
        end
        // shift in bytes of the first port entry
        if (st_q.key == svcb_pkg::KeyPort && !st_q.port_seen) begin
          nx.pend_port = {st_q.pend_port[7:0], b};
        end
        nx.value_left = st_q.value_left - 16'd1;
        if (st_q.value_left == 16'd1) finish = 1'b1;
      end
      default: begin
        // malformed name: rest of record ignored
      end
    endcase

    // close an entry
    if (finish) begin
      if (nx.key == svcb_pkg::KeyMandatory && !nx.mand_seen) begin
        nx.mand_seen    = 1'b1;
        nx.mand_invalid = nx.value_len[0] | nx.pend_invalid;
      end
      if (nx.key == svcb_pkg::KeyPort && !nx.port_seen) begin
        nx.port_seen = 1'b1;
        nx.port_val  = (nx.value_len == 16'd2) ? nx.pend_port : 16'd0;
      end
      nx.phase = PhKeyHi;
    end

    // saturating byte count
    if (st_q.pos != 16'hFFFF) nx.pos = st_q.pos + 16'd1;
  end

  // Result from the post-step state
  assign big_enough = (nx.pos >= 16'd2);
  assign alias_form = big_enough && (nx.pri == 16'd0);

  always_comb begin
    res_o.priority_res = big_enough ? nx.pri : 16'd0;
    res_o.is_alias     = alias_form;
    res_o.name_ok      = big_enough && nx.name_good;
    res_o.record_valid = big_enough && (alias_form || !nx.name_good || !nx.mand_invalid);
    res_o.port         = (big_enough && !alias_form && nx.name_good && nx.port_seen)
                         ? nx.port_val : 16'd0;
  end

  assign res_valid_o = take_i && byte_i.last_byte;

  // Next state: clear after the final byte
  always_comb begin
    st_d = st_q;
    if (take_i) begin
      if (byte_i.last_byte) st_d = '0;
      else st_d = nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

@@ rtl/svcb_rdata_validator_port_extractor_core.sv @@
// SVCB record-data validator and port extractor, top level.
// Accepts one record byte per cycle unless stalled. The result for a record is
// registered when its final byte is accepted, into the skid entry if the output register is not freed.
// A two-entry output buffer (register plus skid) keeps input flowing while a
// result waits; input stalls only when both entries are full.
// Reset clears the parse state and empties the output buffer.
module svcb_rdata_validator_port_extractor_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  svcb_pkg::svcb_in_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output svcb_pkg::svcb_out_t  out_req_o
);

  logic                in_take, res_valid, pop;
  svcb_pkg::svcb_out_t res;
  svcb_pkg::svcb_out_t out_q, out_d, skid_q, skid_d;
  logic                out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  svcb_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_take),
    .byte_i      (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register and skid entry
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_q || (pop && !skid_valid_q)) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
